FILE: sv/assert_macros.svh
// assertion macros shared by the deframer modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define MFCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define MFCD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/mfcd_pkg.sv
// shared types, constants and helpers of the frame chunk deframer
// no dependencies
package mfcd_pkg;

    localparam int NUM_STATIONS    = 16;
    localparam int NUM_PORT_SLOTS  = 8;
    localparam int MAX_FRAME_BYTES = 516;

    localparam int STATION_W   = 4;
    localparam int SLOT_W      = 3;
    localparam int IDX_W       = STATION_W + SLOT_W;
    localparam int TABLE_DEPTH = NUM_STATIONS * NUM_PORT_SLOTS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [15:0] FLAG_SEQ   = 16'h0800;
    localparam logic [15:0] FLAG_MASK  = 16'h1000;
    localparam logic [15:0] SEQ_NONE   = 16'hFFFF;
    localparam logic [15:0] SEQ_UNSEEN = 16'h0001;
    localparam logic [15:0] DUP_WINDOW = 16'h0100;
    localparam logic [9:0]  LEN_FULL   = 10'h200;

    localparam logic [1:0] REG_OWN_STATION = 2'd0;
    localparam logic [1:0] REG_LINK_A      = 2'd1;
    localparam logic [1:0] REG_LINK_B      = 2'd2;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_SEQ     = 3'd3;
    localparam logic [2:0] PH_MASK    = 3'd4;

    // one queued job for the back end
    typedef struct packed {
        logic                 is_seq;
        logic                 is_fin;
        logic                 has_seq;
        logic                 mask_drop;
        logic [IDX_W-1:0]     idx;
        logic [15:0]          seq_word;
        logic [3:0]           port;
        logic [9:0]           offset;
        logic [9:0]           len;
        logic [STATION_W-1:0] src;
        logic [31:0]          tag;
    } t_event;

    // queue status towards front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    function automatic logic [9:0] chunk_len(input logic [15:0] hdr);
        logic [9:0] n;
        n = {1'b0, hdr[7:0], 1'b0};
        return (n == 10'd0) ? LEN_FULL : n;
    endfunction

endpackage

FILE: sv/mfcd_front.sv
// front end: frame and chunk header parsing, emits jobs to the queue
// depends on mfcd_pkg and assert_macros.svh
`include "assert_macros.svh"
module mfcd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_acc,
    input  logic [15:0]                     i_word,
    input  logic                            i_start_of_frame,
    input  logic [9:0]                      i_frame_bytes,
    input  logic [7:0]                      i_source_station,
    input  logic [31:0]                     i_frame_tag,
    input  logic [mfcd_pkg::STATION_W-1:0]  i_own_station,
    output logic                            o_push,
    output mfcd_pkg::t_event                o_event
);
    logic [2:0]  r_phase, n_phase;
    logic [10:0] r_bl, n_bl;
    logic [15:0] r_hdr, n_hdr;
    logic [9:0]  r_cnt, n_cnt;
    logic [9:0]  r_boff, n_boff;
    logic [9:0]  r_pstart, n_pstart;
    logic [mfcd_pkg::STATION_W-1:0] r_src, n_src;
    logic [31:0] r_tag, n_tag;

    logic [10:0] bl_in, need;
    logic [9:0]  clen_in, boff_in, cnt_dec;
    logic        reject, fits;
    logic [2:0]  fin_phase;

    always_comb begin
        reject = (i_frame_bytes == 10'd0)
              || (i_frame_bytes > 10'(mfcd_pkg::MAX_FRAME_BYTES))
              || i_frame_bytes[0]
              || (i_source_station >= 8'(mfcd_pkg::NUM_STATIONS))
              || (i_source_station == {4'd0, i_own_station});
        bl_in   = i_start_of_frame ? {1'b0, i_frame_bytes}
                                   : ((r_bl >= 11'd2) ? r_bl - 11'd2 : 11'd0);
        boff_in = i_start_of_frame ? 10'd0 : r_boff + 10'd2;
        clen_in = mfcd_pkg::chunk_len(i_word);
        need    = {1'b0, clen_in} + ((i_word & mfcd_pkg::FLAG_SEQ) != 16'd0 ? 11'd2 : 11'd0)
                + ((i_word & mfcd_pkg::FLAG_MASK) != 16'd0 ? 11'd2 : 11'd0);
        fits    = need <= bl_in;
        cnt_dec = (r_cnt != 10'd0) ? r_cnt - 10'd1 : 10'd0;
        fin_phase = (r_bl != 11'd0) ? mfcd_pkg::PH_HEADER : mfcd_pkg::PH_IDLE;
    end

    always_comb begin
        n_phase  = r_phase;
        n_bl     = r_bl;
        n_hdr    = r_hdr;
        n_cnt    = r_cnt;
        n_boff   = r_boff;
        n_pstart = r_pstart;
        n_src    = r_src;
        n_tag    = r_tag;
        o_push   = 1'b0;
        o_event.is_seq    = 1'b0;
        o_event.is_fin    = 1'b0;
        o_event.has_seq   = (r_hdr & mfcd_pkg::FLAG_SEQ) != 16'd0;
        o_event.mask_drop = 1'b0;
        o_event.idx       = {r_src, r_hdr[8 +: mfcd_pkg::SLOT_W]};
        o_event.seq_word  = i_word;
        o_event.port      = r_hdr[11:8];
        o_event.offset    = r_pstart;
        o_event.len       = mfcd_pkg::chunk_len(r_hdr);
        o_event.src       = r_src;
        o_event.tag       = r_tag;

        if (i_acc) begin
            if (i_start_of_frame && reject) begin
                n_phase = mfcd_pkg::PH_IDLE;
            end else if (i_start_of_frame || r_phase == mfcd_pkg::PH_HEADER) begin
                if (i_start_of_frame) begin
                    n_src = i_source_station[mfcd_pkg::STATION_W-1:0];
                    n_tag = i_frame_tag;
                end
                n_boff = boff_in;
                // chunk that overruns the frame closes it
                if (fits) begin
                    n_bl     = bl_in - need;
                    n_hdr    = i_word;
                    n_cnt    = {1'b0, clen_in[9:1]};
                    n_pstart = boff_in;
                    n_phase  = mfcd_pkg::PH_PAYLOAD;
                end else begin
                    n_bl    = bl_in;
                    n_phase = mfcd_pkg::PH_IDLE;
                end
            end else if (r_phase != mfcd_pkg::PH_IDLE) begin
                n_boff = boff_in;
                unique case (r_phase)
                    mfcd_pkg::PH_PAYLOAD: begin
                        n_cnt = cnt_dec;
                        if (cnt_dec == 10'd0) begin
                            if ((r_hdr & mfcd_pkg::FLAG_SEQ) != 16'd0) begin
                                n_phase = mfcd_pkg::PH_SEQ;
                            end else if ((r_hdr & mfcd_pkg::FLAG_MASK) != 16'd0) begin
                                n_phase = mfcd_pkg::PH_MASK;
                            end else begin
                                o_push         = 1'b1;
                                o_event.is_fin = 1'b1;
                                n_phase        = fin_phase;
                            end
                        end
                    end
                    mfcd_pkg::PH_SEQ: begin
                        o_push         = 1'b1;
                        o_event.is_seq = 1'b1;
                        if ((r_hdr & mfcd_pkg::FLAG_MASK) != 16'd0) begin
                            n_phase = mfcd_pkg::PH_MASK;
                        end else begin
                            o_event.is_fin = 1'b1;
                            n_phase        = fin_phase;
                        end
                    end
                    mfcd_pkg::PH_MASK: begin
                        o_push            = 1'b1;
                        o_event.is_fin    = 1'b1;
                        o_event.mask_drop = ~i_word[i_own_station];
                        n_phase           = fin_phase;
                    end
                    default: begin
                        n_phase = mfcd_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mfcd_pkg::PH_IDLE;
            r_bl     <= '0;
            r_hdr    <= '0;
            r_cnt    <= '0;
            r_boff   <= '0;
            r_pstart <= '0;
            r_src    <= '0;
            r_tag    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_bl     <= n_bl;
            r_hdr    <= n_hdr;
            r_cnt    <= n_cnt;
            r_boff   <= n_boff;
            r_pstart <= n_pstart;
            r_src    <= n_src;
            r_tag    <= n_tag;
        end
    end

    `MFCD_ASSERT(a_header_has_bytes, i_clk, i_rst_n, (r_phase == mfcd_pkg::PH_HEADER) |-> (r_bl != 11'd0), "header phase with no bytes left")
endmodule

FILE: sv/mfcd_queue.sv
// short job queue between front and back end
// depends on mfcd_pkg and assert_macros.svh
`include "assert_macros.svh"
module mfcd_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  mfcd_pkg::t_event        i_event,
    input  logic                    i_pop,
    output mfcd_pkg::t_event        o_head,
    output mfcd_pkg::t_queue_status o_status
);
    mfcd_pkg::t_event r_mem [mfcd_pkg::QUEUE_DEPTH];
    logic [mfcd_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [mfcd_pkg::QPTR_W:0]   r_count;

    assign o_head         = r_mem[r_rd];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (mfcd_pkg::QPTR_W+1)'(mfcd_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (mfcd_pkg::QPTR_W+1)'(i_push) - (mfcd_pkg::QPTR_W+1)'(i_pop);
        end
    end

    `MFCD_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_status.full && !i_pop, "push into full queue")
    `MFCD_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_status.empty, "pop from empty queue")
endmodule

FILE: sv/mfcd_back.sv
// back end: sequence table check and descriptor output register
// depends on mfcd_pkg and assert_macros.svh
`include "assert_macros.svh"
module mfcd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mfcd_pkg::t_event                i_head,
    input  mfcd_pkg::t_queue_status         i_qstat,
    output logic                            o_pop,
    input  logic [mfcd_pkg::STATION_W-1:0]  i_own_station,
    input  logic [15:0]                     i_link_a,
    input  logic [15:0]                     i_link_b,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [3:0]                      o_port,
    output logic [9:0]                      o_payload_offset,
    output logic [9:0]                      o_payload_bytes,
    output logic [3:0]                      o_from_station,
    output logic [3:0]                      o_station_echo,
    output logic [15:0]                     o_sequence_out,
    output logic [15:0]                     o_link_first,
    output logic [15:0]                     o_link_second,
    output logic [31:0]                     o_tag_out
);
    logic [15:0] r_table [mfcd_pkg::TABLE_DEPTH];
    logic [mfcd_pkg::TABLE_DEPTH-1:0] r_seen;
    logic [15:0] r_rd_data;
    logic        r_rd_seen;

    mfcd_pkg::t_event r_st;
    logic        r_st_valid;
    logic [15:0] r_seq;
    logic        r_dup;

    logic [15:0] entry, dbl, diff;
    logic        seq_step, fin_step, first, dup, wr_en, drop, out_free, st_done, load;

    always_comb begin
        entry    = r_rd_seen ? r_rd_data : mfcd_pkg::SEQ_UNSEEN;
        dbl      = {r_st.seq_word[14:0], 1'b0};
        diff     = entry - dbl;
        first    = entry[0];
        dup      = !first && (diff < mfcd_pkg::DUP_WINDOW);
        seq_step = r_st_valid && r_st.is_seq;
        wr_en    = seq_step && !dup;
        fin_step = r_st_valid && !r_st.is_seq && r_st.is_fin;
        drop     = r_st.mask_drop || (r_st.has_seq && r_dup);
        out_free = !o_valid || !i_stall;
        st_done  = (seq_step && !r_st.is_fin) || (fin_step && (drop || out_free));
        load     = (!r_st_valid || st_done) && !i_qstat.empty;
        o_pop    = load;
    end

    // table read follows the queue head, so data is ready when the job lands
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_table[i_head.idx];
        if (wr_en) begin
            r_table[r_st.idx] <= dbl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_rd_seen <= 1'b0;
        end else begin
            r_rd_seen <= r_seen[i_head.idx];
            if (wr_en) r_seen[r_st.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_valid <= 1'b0;
            r_st       <= '0;
            r_seq      <= mfcd_pkg::SEQ_NONE;
            r_dup      <= 1'b0;
        end else begin
            if (seq_step) begin
                r_seq <= first ? r_st.seq_word : dbl;
                r_dup <= dup;
            end
            if (load) begin
                r_st <= i_head;
            end else if (seq_step) begin
                r_st.is_seq <= 1'b0;
            end
            r_st_valid <= load || (r_st_valid && !st_done);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (fin_step && !drop && out_free) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_step && !drop && out_free) begin
            o_port           <= r_st.port;
            o_payload_offset <= r_st.offset;
            o_payload_bytes  <= r_st.len;
            o_from_station   <= r_st.src;
            o_station_echo   <= i_own_station;
            o_sequence_out   <= r_st.has_seq ? r_seq : mfcd_pkg::SEQ_NONE;
            o_link_first     <= (i_own_station == '0) ? i_link_a : i_link_b;
            o_link_second    <= (i_own_station == '0) ? i_link_b : i_link_a;
            o_tag_out        <= r_st.tag;
        end
    end

    `MFCD_ASSERT(a_seq_then_fin, i_clk, i_rst_n, (r_st_valid && r_st.is_seq && r_st.is_fin) |=> (r_st_valid && !r_st.is_seq), "sequence step not followed by finish")
endmodule

FILE: sv/multiplexed_frame_chunk_deframer.sv
// top level of the frame chunk deframer: config registers, front, queue, back
// depends on mfcd_pkg, mfcd_front, mfcd_queue, mfcd_back and assert_macros.svh
//
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      word, start, frame bytes, source, tag
// output    out        o_valid / i_stall      one descriptor per chunk not masked or duplicate
// config    in         i_cfg_we (no wait)     index, 16-bit data
//
// one input transaction a cycle while the queue is not full; a descriptor is registered
// after its job has passed the job queue and the back-end stage register
// in the back end a chunk with a sequence word takes a table read-modify-write step first
// a 4-deep job queue lets the front run on while the output is stalled
// input stalls only when that queue is full; reset is synchronous, all table entries read unseen
`include "assert_macros.svh"
module multiplexed_frame_chunk_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_word,
    input  logic        i_start_of_frame,
    input  logic [9:0]  i_frame_bytes,
    input  logic [7:0]  i_source_station,
    input  logic [31:0] i_frame_tag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_port,
    output logic [9:0]  o_payload_offset,
    output logic [9:0]  o_payload_bytes,
    output logic [3:0]  o_from_station,
    output logic [3:0]  o_station_echo,
    output logic [15:0] o_sequence_out,
    output logic [15:0] o_link_first,
    output logic [15:0] o_link_second,
    output logic [31:0] o_tag_out
);
    // configuration registers
    logic [mfcd_pkg::STATION_W-1:0] r_own_station;
    logic [15:0] r_link_a, r_link_b;

    mfcd_pkg::t_event        push_event, head_event;
    mfcd_pkg::t_queue_status qstat;
    logic push, pop, acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_station <= '0;
            r_link_a      <= '0;
            r_link_b      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mfcd_pkg::REG_OWN_STATION: r_own_station <= i_cfg_data[mfcd_pkg::STATION_W-1:0];
                mfcd_pkg::REG_LINK_A:      r_link_a      <= i_cfg_data;
                mfcd_pkg::REG_LINK_B:      r_link_b      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stall only on a full queue, so every accepted transaction may queue a job
    assign o_stall = qstat.full;
    assign acc     = i_valid && !o_stall;

    mfcd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_acc            (acc),
        .i_word           (i_word),
        .i_start_of_frame (i_start_of_frame),
        .i_frame_bytes    (i_frame_bytes),
        .i_source_station (i_source_station),
        .i_frame_tag      (i_frame_tag),
        .i_own_station    (r_own_station),
        .o_push           (push),
        .o_event          (push_event)
    );

    mfcd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_event  (push_event),
        .i_pop    (pop),
        .o_head   (head_event),
        .o_status (qstat)
    );

    mfcd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head_event),
        .i_qstat          (qstat),
        .o_pop            (pop),
        .i_own_station    (r_own_station),
        .i_link_a         (r_link_a),
        .i_link_b         (r_link_b),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_port           (o_port),
        .o_payload_offset (o_payload_offset),
        .o_payload_bytes  (o_payload_bytes),
        .o_from_station   (o_from_station),
        .o_station_echo   (o_station_echo),
        .o_sequence_out   (o_sequence_out),
        .o_link_first     (o_link_first),
        .o_link_second    (o_link_second),
        .o_tag_out        (o_tag_out)
    );

    `MFCD_ASSERT_NEVER(a_push_needs_accept, i_clk, i_rst_n, push && !acc, "job queued without an accepted transaction")
endmodule
